### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

### src/swrk_pkg.sv
// ----------------------------------------------------------------------------
// swrk_pkg
// types and constants of the key stack with remove by key
// ----------------------------------------------------------------------------
package swrk_pkg;

  localparam int KEY_W = 56;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_from_rd;
  } mem_ctrl_t;

endpackage

### src/swrk_mem.sv
// ----------------------------------------------------------------------------
// swrk_mem
// key store with one read and one write port and the shared key comparator
// ----------------------------------------------------------------------------
module swrk_mem import swrk_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_ctrl_t        ctl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] key,
  output logic             match
);

  logic [KEY_W-1:0] store [DEPTH];
  logic [KEY_W-1:0] rd_data;
  logic [KEY_W-1:0] wr_data;

  assign wr_data = ctl.wr_from_rd ? rd_data : key;
  assign match   = (rd_data == key);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

### src/swrk_ctrl.sv
// ----------------------------------------------------------------------------
// swrk_ctrl
// sequencer: push, pop, top-down search and gap closing over the key store
// ----------------------------------------------------------------------------
module swrk_ctrl import swrk_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  request_t         req,
  input  logic             take,
  input  logic             match,
  output logic             ready,
  output mem_ctrl_t        mctl,
  output logic [AW-1:0]    rd_addr,
  output logic [AW-1:0]    wr_addr,
  output logic [KEY_W-1:0] key,
  output logic             res_load,
  output result_t          res
);

  state_t        state, state_next;
  cmd_t          cmd;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] pidx, pidx_next;
  logic          pend, pend_next;
  logic          more, more_next;
  status_t       status, status_next;
  logic [CW-1:0] top_idx;

  assign top_idx = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      more  <= more_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd <= req.command;
      key <= req.key;
    end
    ptr    <= ptr_next;
    pidx   <= pidx_next;
    status <= status_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    pidx_next    = pidx;
    pend_next    = pend;
    more_next    = more;
    status_next  = status;
    ready        = 1'b0;
    mctl         = '0;
    rd_addr      = ptr;
    wr_addr      = count[AW-1:0];
    res_load     = 1'b0;
    res.status    = status;
    res.occupancy = OCC_W'(count);
    case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next  = S_DONE;
        status_next = STAT_OK;
        case (cmd)
          CMD_PUSH: begin
            if (count == CW'(DEPTH)) begin
              status_next = STAT_FULL;
            end else begin
              mctl.wr_en = 1'b1;
              count_next = count + CW'(1);
            end
          end
          CMD_POP: begin
            if (count == '0) begin
              status_next = STAT_EMPTY;
            end else begin
              count_next = top_idx;
            end
          end
          CMD_REMOVE: begin
            if (count == '0) begin
              status_next = STAT_NOT_FOUND;
            end else begin
              ptr_next   = top_idx[AW-1:0];
              pend_next  = 1'b0;
              more_next  = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (pend && match) begin
          pend_next = 1'b0;
          if (CW'(pidx) == top_idx) begin
            count_next = top_idx;
            state_next = S_DONE;
          end else begin
            ptr_next   = pidx + AW'(1);
            more_next  = 1'b1;
            state_next = S_SHIFT;
          end
        end else if (pend && pidx == '0) begin
          pend_next   = 1'b0;
          status_next = STAT_NOT_FOUND;
          state_next  = S_DONE;
        end else begin
          mctl.rd_en = more;
          pend_next  = more;
          pidx_next  = ptr;
          more_next  = more && (ptr != '0);
          if (more) begin
            ptr_next = ptr - AW'(1);
          end
        end
      end
      S_SHIFT: begin
        wr_addr         = pidx - AW'(1);
        mctl.wr_from_rd = 1'b1;
        mctl.wr_en      = pend;
        mctl.rd_en      = more;
        pend_next       = more;
        pidx_next       = ptr;
        if (more) begin
          ptr_next  = ptr + AW'(1);
          more_next = (CW'(ptr) != top_idx);
        end
        if (!more && !pend) begin
          count_next = top_idx;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/stack_with_remove_by_key.sv
// ----------------------------------------------------------------------------
// stack_with_remove_by_key
// bounded stack of 56-bit keys with push, pop and remove of the topmost match
// ----------------------------------------------------------------------------
// One request is handled at a time, and each yields one response with a status
// and the entry count afterwards. Push, pop and the unused command go through
// the execute state and the done state to the response register. Remove reads
// the key store through its single read port, one entry per cycle from the top
// down, then closes the gap with one read and one write per cycle. A new request
// is taken once the previous response has been loaded into the output register,
// even while that response waits.
module stack_with_remove_by_key import swrk_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  request_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output result_t  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctrl_t        mctl;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] key;
  logic             match;
  logic             ready;
  logic             take;
  logic             res_load;
  result_t          res;

  assign req_stall = !ready;
  assign take      = !rsp_valid || !rsp_stall;

  swrk_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .take     (take),
    .match    (match),
    .ready    (ready),
    .mctl     (mctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .key      (key),
    .res_load (res_load),
    .res      (res)
  );

  swrk_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk    (clk),
    .ctl    (mctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .key    (key),
    .match  (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

### src/swrk_checker.sv
// ----------------------------------------------------------------------------
// swrk_checker
// port-level checks of the key stack, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swrk_checker import swrk_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input request_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input result_t  rsp
);

  // a stalled response holds
  `ASSERT_PROP(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
  // a transaction in progress blocks the next request
  `ASSERT_PROP(a_busy_after_req, clk, rst, req_valid && !req_stall |=> req_stall)
  // full is only reported with the stack full
  `ASSERT_PROP(a_full_count, clk, rst,
    rsp_valid && rsp.status == STAT_FULL |-> rsp.occupancy == OCC_W'(DEPTH))
  // empty is only reported with the stack empty
  `ASSERT_NEVER(a_empty_count, clk, rst,
    rsp_valid && rsp.status == STAT_EMPTY && rsp.occupancy != '0)

endmodule

bind stack_with_remove_by_key swrk_checker #(.DEPTH(DEPTH)) u_checker (.*);
